// ----- design/sll_pkg.sv -----
// Shared constants and types for the static linked list engine.
package sll_pkg;

    localparam int OP_W  = 1;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int LEN_W = 10;
    localparam int IDX_W = 10;   // widest slot index the engine supports

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_READ   = 1'b1;

    // Write command from the sequencer to the list store.
    typedef struct packed {
        logic              link_we;
        logic              val_we;
        logic [IDX_W-1:0]  addr;
        logic [IDX_W-1:0]  link;
        logic [VAL_W-1:0]  value;
    } t_wr_cmd;

endpackage

// ----- design/sll_if.sv -----
// Channel interfaces: request words in, result words out.
interface sll_item_if;
    logic                            valid;
    logic                            ready;
    logic [sll_pkg::OP_W-1:0]        operation;
    logic [sll_pkg::POS_W-1:0]       position;
    logic signed [sll_pkg::VAL_W-1:0] item_value;

    modport source (output valid, operation, position, item_value, input ready);
    modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface sll_result_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic signed [sll_pkg::VAL_W-1:0] read_value;
    logic [sll_pkg::LEN_W-1:0]       list_length;

    modport source (output valid, ok, read_value, list_length, input ready);
    modport sink   (input valid, ok, read_value, list_length, output ready);
endinterface

// ----- design/sll_store.sv -----
// Link and value memories plus the head link register.
module sll_store #(
    parameter int SLOTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(SLOTS)-1:0]     i_raddr,
    input  sll_pkg::t_wr_cmd             i_wr,
    output logic [$clog2(SLOTS)-1:0]     o_next,
    output logic [sll_pkg::VAL_W-1:0]    o_rd_val
);
    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0]               r_link_mem [SLOTS];
    logic [sll_pkg::VAL_W-1:0]   r_val_mem  [SLOTS];
    logic [IW-1:0]               r_head;
    logic [IW-1:0]               r_raddr;
    logic [IW-1:0]               r_link_rd;
    logic [sll_pkg::VAL_W-1:0]   r_val_rd;
    logic [IW-1:0]               n_head;
    logic [IW-1:0]               w_addr;
    logic [IW-1:0]               w_link;

    assign w_addr = i_wr.addr[IW-1:0];
    assign w_link = i_wr.link[IW-1:0];

    // slot 0 is the head; its link lives in a register
    always_comb begin
        n_head = r_head;
        if (i_wr.link_we && w_addr == '0) begin
            n_head = w_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.link_we && w_addr != '0) begin
            r_link_mem[w_addr] <= w_link;
        end
        if (i_wr.val_we) begin
            r_val_mem[w_addr] <= i_wr.value;
        end
        r_link_rd <= r_link_mem[i_raddr];
        r_val_rd  <= r_val_mem[i_raddr];
        r_raddr   <= i_raddr;
    end

    assign o_next   = (r_raddr == '0) ? r_head : r_link_rd;
    assign o_rd_val = r_val_rd;

endmodule

// ----- design/sll_seq.sv -----
// Sequencer: walks links one hop per cycle and issues the splice writes.
module sll_seq #(
    parameter int SLOTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sll_pkg::OP_W-1:0]     i_op,
    input  logic [sll_pkg::POS_W-1:0]    i_pos,
    input  logic [sll_pkg::VAL_W-1:0]    i_val,
    input  logic [$clog2(SLOTS)-1:0]     i_next,
    input  logic [sll_pkg::VAL_W-1:0]    i_rd_val,
    input  logic                         i_res_free,
    output logic [$clog2(SLOTS)-1:0]     o_raddr,
    output sll_pkg::t_wr_cmd             o_wr,
    output logic                         o_idle,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [sll_pkg::VAL_W-1:0]    o_read_value,
    output logic [sll_pkg::LEN_W-1:0]    o_length
);
    localparam int IW = $clog2(SLOTS);
    localparam int XW = sll_pkg::IDX_W;
    localparam int PW = sll_pkg::POS_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_LINK   = 3'd2;
    localparam logic [2:0] ST_SPLICE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [sll_pkg::OP_W-1:0]    r_op, n_op;
    logic [sll_pkg::VAL_W-1:0]   r_val, n_val;
    logic [PW-1:0]               r_rem, n_rem;
    logic [IW-1:0]               r_cur, n_cur;
    logic [IW-1:0]               r_count, n_count;
    logic                        r_ok, n_ok;
    logic [sll_pkg::VAL_W-1:0]   r_rd, n_rd;
    logic [IW-1:0]               w_free;
    logic                        w_full;

    // no deletes: slots are handed out in order, so the free head is count+1
    assign w_free = r_count + IW'(1);
    assign w_full = (r_count == IW'(SLOTS - 1));

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_val   = r_val;
        n_rem   = r_rem;
        n_cur   = r_cur;
        n_count = r_count;
        n_ok    = r_ok;
        n_rd    = r_rd;
        o_raddr = r_cur;
        o_wr    = '0;
        case (r_state)
            ST_IDLE: begin
                o_raddr = '0;
                if (i_start) begin
                    n_op  = i_op;
                    n_val = i_val;
                    n_cur = '0;
                    n_ok  = 1'b0;
                    n_rd  = '0;
                    if (i_pos == '0 || (i_op == sll_pkg::OP_INSERT && w_full)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_rem   = (i_op == sll_pkg::OP_INSERT) ? i_pos - PW'(1) : i_pos;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_rem == '0) begin
                    if (r_op == sll_pkg::OP_INSERT) begin
                        n_state = ST_LINK;
                    end else begin
                        n_ok    = 1'b1;
                        n_rd    = i_rd_val;
                        n_state = ST_DONE;
                    end
                end else if (i_next == '0) begin
                    n_state = ST_DONE;   // ran off the end
                end else begin
                    o_raddr = i_next;
                    n_cur   = i_next;
                    n_rem   = r_rem - PW'(1);
                end
            end
            ST_LINK: begin
                o_wr.link_we = 1'b1;
                o_wr.val_we  = 1'b1;
                o_wr.addr    = XW'(w_free);
                o_wr.link    = XW'(i_next);
                o_wr.value   = r_val;
                n_state      = ST_SPLICE;
            end
            ST_SPLICE: begin
                o_wr.link_we = 1'b1;
                o_wr.addr    = XW'(r_cur);
                o_wr.link    = XW'(w_free);
                n_count      = r_count + IW'(1);
                n_ok         = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_rem <= n_rem;
        r_cur <= n_cur;
        r_ok  <= n_ok;
        r_rd  <= n_rd;
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_done       = (r_state == ST_DONE);
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_length     = sll_pkg::LEN_W'(r_count);

endmodule

// ----- design/static_linked_list_engine_core.sv -----
// Top level of the static linked list engine.
// Array-backed singly linked list, SLOTS slots; slot 0 is the head and
// index 0 means "none". Request words arrive on i_item (operation,
// position, item_value); each one yields exactly one result word on
// o_result (ok, read_value, list_length). Both channels use valid/ready.
// Insert puts item_value at 1-based position; read returns the value there.
// Timing: one request at a time. A word is taken only while the sequencer
// is idle, then the link walk runs one hop per cycle through the link
// memory's registered read port. After its walk an insert passes through
// ST_LINK and ST_SPLICE to ST_DONE, a read goes straight to ST_DONE, and
// position 0 or a full-list insert fails without a walk. A walk stops
// early at the list's end, bounded by its length (at most SLOTS-1 hops).
// The result sits in an output register; a new request is accepted while
// it waits, and the sequencer holds its finished result until the
// register frees up when o_result is stalled.
// Reset (i_rst_n low, synchronous) empties the list at once: head link,
// count and control clear; no memory sweep is needed because slots are
// handed out in order and never freed, so stale entries are never walked.
module static_linked_list_engine_core #(
    parameter int SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sll_item_if.sink             i_item,
    sll_result_if.source         o_result
);
    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0]                  w_raddr;
    logic [IW-1:0]                  w_next;
    logic [sll_pkg::VAL_W-1:0]      w_rd_val;
    sll_pkg::t_wr_cmd               w_wr;
    logic                           w_idle;
    logic                           w_done;
    logic                           w_ok;
    logic [sll_pkg::VAL_W-1:0]      w_read_value;
    logic [sll_pkg::LEN_W-1:0]      w_length;
    logic                           w_res_free;
    logic                           w_start;

    logic                           r_out_valid, n_out_valid;
    logic                           r_out_ok;
    logic [sll_pkg::VAL_W-1:0]      r_out_value;
    logic [sll_pkg::LEN_W-1:0]      r_out_len;

    assign i_item.ready = w_idle;
    assign w_start      = i_item.valid && w_idle;

    // output register can take a word when empty or being drained
    assign w_res_free   = !r_out_valid || o_result.ready;

    sll_seq #(.SLOTS(SLOTS)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_op         (i_item.operation),
        .i_pos        (i_item.position),
        .i_val        (i_item.item_value),
        .i_next       (w_next),
        .i_rd_val     (w_rd_val),
        .i_res_free   (w_res_free),
        .o_raddr      (w_raddr),
        .o_wr         (w_wr),
        .o_idle       (w_idle),
        .o_done       (w_done),
        .o_ok         (w_ok),
        .o_read_value (w_read_value),
        .o_length     (w_length)
    );

    sll_store #(.SLOTS(SLOTS)) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_raddr  (w_raddr),
        .i_wr     (w_wr),
        .o_next   (w_next),
        .o_rd_val (w_rd_val)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done && w_res_free) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_res_free) begin
            r_out_ok    <= w_ok;
            r_out_value <= w_read_value;
            r_out_len   <= w_length;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.ok          = r_out_ok;
    assign o_result.read_value  = r_out_value;
    assign o_result.list_length = r_out_len;

endmodule

// ----- design/sll_checker.sv -----
// Port-level checks for the static linked list engine, bound to the top.
module sll_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_ok,
    input logic [sll_pkg::VAL_W-1:0]     i_out_value,
    input logic [sll_pkg::LEN_W-1:0]     i_out_len
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ok)
            && $stable(i_out_value) && $stable(i_out_len))
        else $error("result word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // one request at a time: busy in the cycle after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while walking");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_value != '0 |-> i_out_ok)
        else $error("nonzero read value on a failed word");

endmodule

bind static_linked_list_engine_core sll_checker u_sll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_ok    (o_result.ok),
    .i_out_value (o_result.read_value),
    .i_out_len   (o_result.list_length)
);

// ----- sim/testbench.sv -----
// Testbench for the static linked list engine: directed, random and stall tests.
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS       = 8;
    localparam int LONG_HOLD   = 80;     // cycles the result side holds off
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic                             ok;
        logic signed [sll_pkg::VAL_W-1:0] read_value;
        logic [sll_pkg::LEN_W-1:0]        list_length;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    sll_item_if   item_ch ();
    sll_result_if result_ch ();

    static_linked_list_engine_core #(
        .SLOTS (SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Shadow copy of the list: links, values, free chain head and length.
    int                               shadow_link [SLOTS];
    logic signed [sll_pkg::VAL_W-1:0] shadow_value [SLOTS];
    int                               shadow_free_head;
    logic [sll_pkg::LEN_W-1:0]        shadow_length;

    t_list_result pending_results [$];
    int           mismatch_count;
    bit           idle_en;
    bit           long_hold_req;
    int           quiet_cycles;

    always #1 i_clk = ~i_clk;

    // Any link at or beyond SLOTS means "none".
    function automatic int clip_slot(int idx);
        return (idx >= 0 && idx < SLOTS) ? idx : 0;
    endfunction

    function automatic int next_slot(int idx);
        return clip_slot(shadow_link[clip_slot(idx)]);
    endfunction

    function automatic void reset_shadow_list();
        shadow_link[0] = 0;
        for (int i = 1; i < SLOTS - 1; i++) begin
            shadow_link[i] = i + 1;
        end
        shadow_link[SLOTS-1] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_value[i] = '0;
        end
        shadow_free_head = 1;
        shadow_length    = '0;
    endfunction

    // Apply one request to the shadow list and return the result it yields.
    function automatic t_list_result apply_list_request(
            logic [sll_pkg::OP_W-1:0] op,
            logic [sll_pkg::POS_W-1:0] pos,
            logic signed [sll_pkg::VAL_W-1:0] val);
        t_list_result res;
        int           free_slot;
        int           pred;
        int           cur;
        bit           past_end;
        res.ok         = 1'b0;
        res.read_value = '0;
        if (op == sll_pkg::OP_INSERT) begin
            free_slot = clip_slot(shadow_free_head);
            if (pos >= 1 && free_slot != 0) begin
                // walk pos-1 links to the predecessor
                pred     = 0;
                past_end = 1'b0;
                for (int j = 1; j < pos; j++) begin
                    pred = next_slot(pred);
                    if (pred == 0) begin
                        past_end = 1'b1;
                        break;
                    end
                end
                if (!past_end) begin
                    shadow_free_head        = next_slot(free_slot);
                    shadow_value[free_slot] = val;
                    shadow_link[free_slot]  = next_slot(pred);
                    shadow_link[pred]       = free_slot;
                    shadow_length           = shadow_length + 1'b1;
                    res.ok                  = 1'b1;
                end
            end
        end else begin
            if (pos >= 1) begin
                cur = next_slot(0);
                for (int j = 1; j < pos && cur != 0; j++) begin
                    cur = next_slot(cur);
                end
                if (cur != 0) begin
                    res.ok         = 1'b1;
                    res.read_value = shadow_value[cur];
                end
            end
        end
        res.list_length = shadow_length;
        return res;
    endfunction

    // Offer one request word; entered and left at a falling edge.
    task automatic send_list_request(logic [sll_pkg::OP_W-1:0] op,
                                     logic [sll_pkg::POS_W-1:0] pos,
                                     logic signed [sll_pkg::VAL_W-1:0] val);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid      = 1'b1;
        item_ch.operation  = op;
        item_ch.position   = pos;
        item_ch.item_value = val;
        do begin
            @(posedge i_clk);
        end while (!item_ch.ready);
        pending_results.push_back(apply_list_request(op, pos, val));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        item_ch.valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        stop_sending();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [sll_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Empty list: position zero and anything past the end must fail.
    task automatic test_empty_list();
        send_list_request(sll_pkg::OP_READ,   8'd0, 32'sd5);
        send_list_request(sll_pkg::OP_READ,   8'd1, 32'sd0);
        send_list_request(sll_pkg::OP_INSERT, 8'd0, 32'sd17);
        send_list_request(sll_pkg::OP_INSERT, 8'd2, 32'sd23);
    endtask

    // Insert at front, end and middle, then read every position back.
    task automatic test_insert_read();
        send_list_request(sll_pkg::OP_INSERT, 8'd1, 32'sh7FFF_FFFF);
        send_list_request(sll_pkg::OP_INSERT, 8'd1, 32'sh8000_0000);
        send_list_request(sll_pkg::OP_INSERT, 8'd3, 32'sd0);
        send_list_request(sll_pkg::OP_INSERT, 8'd2, -32'sd1);
        send_list_request(sll_pkg::OP_INSERT, 8'd6, 32'sh1234_5678);
        for (int p = 1; p <= 5; p++) begin
            send_list_request(sll_pkg::OP_READ, p[sll_pkg::POS_W-1:0], $urandom());
        end
        send_list_request(sll_pkg::OP_READ,   8'd255, 32'sd0);
        send_list_request(sll_pkg::OP_READ,   8'd0,   32'sd0);
        send_list_request(sll_pkg::OP_INSERT, 8'd255, 32'sh5A5A_5A5A);
        wait_results_drained();
    endtask

    // Hold the result side off while requests keep coming, so the engine
    // backs up and stalls its input; then pause until all results are in.
    task automatic test_result_backpressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_list_request(sll_pkg::OP_READ,
                              sll_pkg::POS_W'($urandom_range(0, int'(shadow_length) + 1)),
                              $urandom());
        end
        wait_results_drained();
    endtask

    // Mixed inserts and reads, mostly at positions from 0 to one past the list end.
    task automatic test_random_mix(int count);
        logic [sll_pkg::OP_W-1:0]  op;
        logic [sll_pkg::POS_W-1:0] pos;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < 45) ? sll_pkg::OP_INSERT : sll_pkg::OP_READ;
            if ($urandom_range(0, 9) < 7) begin
                pos = sll_pkg::POS_W'($urandom_range(0, int'(shadow_length) + 1));
            end else begin
                pos = sll_pkg::POS_W'($urandom_range(0, 255));
            end
            send_list_request(op, pos, pick_value());
        end
    endtask

    // Top the list up to capacity, then inserts must fail anywhere.
    task automatic test_full_list();
        while (shadow_length < SLOTS - 1) begin
            send_list_request(sll_pkg::OP_INSERT,
                              sll_pkg::POS_W'(int'(shadow_length) + 1), pick_value());
        end
        send_list_request(sll_pkg::OP_INSERT, 8'd1, 32'sh0BAD_F00D);
        send_list_request(sll_pkg::OP_INSERT, sll_pkg::POS_W'(SLOTS), 32'sh7FFF_FFFF);
        send_list_request(sll_pkg::OP_READ,   sll_pkg::POS_W'(SLOTS - 1), 32'sd0);
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_no_idle(int count);
        wait_results_drained();
        idle_en = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_list_request(($urandom_range(0, 3) == 0) ? sll_pkg::OP_INSERT
                                                           : sll_pkg::OP_READ,
                              sll_pkg::POS_W'($urandom_range(0, SLOTS)), pick_value());
        end
        stop_sending();
    endtask

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req   = 1'b0;
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                result_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end else begin
                result_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("[%0t] unexpected result word: ok=%0b value=%0d length=%0d",
                             $realtime, result_ch.ok, result_ch.read_value,
                             result_ch.list_length);
                end
            end else begin
                want = pending_results.pop_front();
                if (result_ch.ok !== want.ok || result_ch.read_value !== want.read_value
                        || result_ch.list_length !== want.list_length) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("[%0t] result mismatch: ok %0b/%0b value %0d/%0d length %0d/%0d (exp/act)",
                                 $realtime, want.ok, result_ch.ok, want.read_value,
                                 result_ch.read_value, want.list_length,
                                 result_ch.list_length);
                    end
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.operation  = sll_pkg::OP_INSERT;
        item_ch.position   = '0;
        item_ch.item_value = '0;
        mismatch_count     = 0;
        quiet_cycles       = 0;
        idle_en            = 1'b1;
        long_hold_req      = 1'b0;
        reset_shadow_list();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_insert_read();
        test_result_backpressure();
        test_random_mix(1260);
        test_full_list();
        test_no_idle(40);

        wait_results_drained();
        repeat (16) @(posedge i_clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
